@@ hdl/dependency_level_assigner_unit_assert.svh @@
// assertion macros for the dependency level assigner
// expects clk and rst in the scope where a macro is used
`ifndef DEPENDENCY_LEVEL_ASSIGNER_UNIT_ASSERT_SVH
`define DEPENDENCY_LEVEL_ASSIGNER_UNIT_ASSERT_SVH

// condition implies a check in the same cycle
`define DLA_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition implies a check in the following cycle
`define DLA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/dla_pkg.sv @@
// shared types, constants and helper functions for the dependency level assigner
// no dependencies
package dla_pkg;

  localparam int IDX_W = 6;
  localparam int IDX_SPAN = 1 << IDX_W;
  localparam int LEVEL_BITS = 10;
  localparam int NUM_BUFFERS_DEF = 64;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [LEVEL_BITS-1:0] level_t;

  localparam level_t LEVEL_MAX = '1;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_MUL = 1'b1;

  typedef struct packed {
    logic req_type;
    idx_t dest_tensor;
    idx_t src_a;
    idx_t src_b;
    logic new_set;
  } req_t;

  typedef struct packed {
    level_t level;
    level_t level_count_minus_one;
  } rsp_t;

  // classified request held in the queue between front and back
  typedef struct packed {
    logic fresh;
    logic dst_ok;
    logic a_ok;
    logic b_ok;
    idx_t dst;
    idx_t sa;
    idx_t sb;
  } op_t;

  typedef struct packed {
    logic issue;
    logic push;
  } stat_t;

  // only IDX_SPAN buffers can ever be named by a request
  function automatic int table_depth(input int n);
    return (n < IDX_SPAN) ? n : IDX_SPAN;
  endfunction

  function automatic level_t sat_inc(input level_t v);
    return (v == LEVEL_MAX) ? v : v + level_t'(1);
  endfunction

  function automatic level_t lvl_max(input level_t a, input level_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

@@ hdl/dla_front.sv @@
// front part: accepts requests, classifies buffer indexes, two-entry queue
// depends on dla_pkg
module dla_front import dla_pkg::*; #(
  parameter int NUM_BUFFERS = NUM_BUFFERS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic op_valid,
  input  logic op_pop,
  output op_t  op
);

  localparam int DEPTH = table_depth(NUM_BUFFERS);

  op_t        fifo_mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;
  logic       push;
  op_t        op_in;

  always_comb begin
    op_in.fresh  = req.new_set;
    op_in.dst_ok = 32'(req.dest_tensor) < DEPTH;
    op_in.a_ok   = 32'(req.src_a) < DEPTH;
    op_in.b_ok   = (req.req_type == OP_MUL) && (32'(req.src_b) < DEPTH);
    op_in.dst    = req.dest_tensor;
    op_in.sa     = req.src_a;
    op_in.sb     = req.src_b;
  end

  assign req_stall = (count == 2'd2);
  assign push      = req_valid && !req_stall;
  assign op_valid  = (count != 2'd0);
  assign op        = fifo_mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !op_pop) begin
      count_next = count + 2'd1;
    end else if (op_pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (op_pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= op_in;
    end
  end

endmodule

@@ hdl/dla_back.sv @@
// back part: level tables, level computation and table updates
// depends on dla_pkg
module dla_back import dla_pkg::*; #(
  parameter int NUM_BUFFERS = NUM_BUFFERS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  op_valid,
  input  op_t   op,
  output logic  op_pop,
  input  logic  room,
  output logic  push,
  output rsp_t  rsp,
  output stat_t stat
);

  localparam int DEPTH = table_depth(NUM_BUFFERS);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // two copies of each table give enough read ports
  level_t wr_tab0 [DEPTH];
  level_t wr_tab1 [DEPTH];
  level_t rd_tab0 [DEPTH];
  level_t rd_tab1 [DEPTH];
  logic [DEPTH-1:0] writer_valid;
  logic [DEPTH-1:0] reader_valid;

  logic   issue;
  logic   s1;
  op_t    s1_op;
  level_t wa_q, wb_q, wd_q, rd_q, ra_q, rb_q;
  logic   wv_a, wv_b, wv_d, rv_d, rv_a, rv_b;
  logic   hit_d, hit_a, hit_b;
  level_t fwd_val;
  logic   pend;
  logic [AW-1:0] pend_addr;
  level_t pend_val;
  level_t highest;

  logic [AW-1:0] i_d, i_a, i_b;
  logic [AW-1:0] c_d, c_a, c_b;
  level_t rd_eff, ra_eff, rb_eff;
  level_t e_a, e_b, e_d, lvl, w_new, ra_new, rb_new, base, hi_new;
  logic          rd_we;
  logic [AW-1:0] rd_wa;
  level_t        rd_wd;

  assign i_d = op.dst[AW-1:0];
  assign i_a = op.sa[AW-1:0];
  assign i_b = op.sb[AW-1:0];
  assign c_d = s1_op.dst[AW-1:0];
  assign c_a = s1_op.sa[AW-1:0];
  assign c_b = s1_op.sb[AW-1:0];

  assign issue  = op_valid && !s1 && room;
  assign op_pop = issue;

  // issue: table reads and valid capture
  always_ff @(posedge clk) begin
    if (issue) begin
      wa_q    <= wr_tab0[i_a];
      wb_q    <= wr_tab0[i_b];
      wd_q    <= wr_tab1[i_d];
      rd_q    <= rd_tab0[i_d];
      ra_q    <= rd_tab0[i_a];
      rb_q    <= rd_tab1[i_b];
      wv_a    <= op.a_ok && !op.fresh && writer_valid[i_a];
      wv_b    <= op.b_ok && !op.fresh && writer_valid[i_b];
      wv_d    <= op.dst_ok && !op.fresh && writer_valid[i_d];
      rv_d    <= op.dst_ok && !op.fresh && reader_valid[i_d];
      rv_a    <= op.a_ok && !op.fresh && reader_valid[i_a];
      rv_b    <= op.b_ok && !op.fresh && reader_valid[i_b];
      hit_d   <= pend && (pend_addr == i_d);
      hit_a   <= pend && (pend_addr == i_a);
      hit_b   <= pend && (pend_addr == i_b);
      fwd_val <= pend_val;
      s1_op   <= op;
    end
  end

  // compute: level and updated table values
  always_comb begin
    rd_eff = hit_d ? fwd_val : rd_q;
    ra_eff = hit_a ? fwd_val : ra_q;
    rb_eff = hit_b ? fwd_val : rb_q;
    e_a    = wv_a ? sat_inc(wa_q) : '0;
    e_b    = wv_b ? sat_inc(wb_q) : '0;
    e_d    = rv_d ? sat_inc(rd_eff) : '0;
    lvl    = lvl_max(lvl_max(e_a, e_b), e_d);
    w_new  = (wv_d && (wd_q > lvl)) ? wd_q : lvl;
    ra_new = (rv_a && (ra_eff > lvl)) ? ra_eff : lvl;
    rb_new = (rv_b && (rb_eff > lvl)) ? rb_eff : lvl;
    base   = s1_op.fresh ? '0 : highest;
    hi_new = lvl_max(lvl, base);
  end

  assign push = s1;
  assign rsp.level = lvl;
  assign rsp.level_count_minus_one = hi_new;
  assign stat.issue = issue;
  assign stat.push  = push;

  // reader table takes src_a in the compute cycle and src_b in the cycle after
  assign rd_we = (s1 && s1_op.a_ok) || pend;
  assign rd_wa = s1 ? c_a : pend_addr;
  assign rd_wd = s1 ? ra_new : pend_val;

  always_ff @(posedge clk) begin
    if (s1 && s1_op.dst_ok) begin
      wr_tab0[c_d] <= w_new;
      wr_tab1[c_d] <= w_new;
    end
    if (rd_we) begin
      rd_tab0[rd_wa] <= rd_wd;
      rd_tab1[rd_wa] <= rd_wd;
    end
    if (s1) begin
      pend_addr <= c_b;
      pend_val  <= rb_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1           <= 1'b0;
      pend         <= 1'b0;
      highest      <= '0;
      writer_valid <= '0;
      reader_valid <= '0;
    end else begin
      s1   <= issue;
      pend <= s1 && s1_op.b_ok;
      if (s1) begin
        highest <= hi_new;
        if (s1_op.dst_ok) begin
          writer_valid[c_d] <= 1'b1;
        end
        if (s1_op.a_ok) begin
          reader_valid[c_a] <= 1'b1;
        end
        if (s1_op.b_ok) begin
          reader_valid[c_b] <= 1'b1;
        end
      end
      if (issue && op.fresh) begin
        writer_valid <= '0;
        reader_valid <= '0;
      end
    end
  end

endmodule

@@ hdl/dla_out.sv @@
// two-entry result buffer between back part and response channel
// depends on dla_pkg
module dla_out import dla_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  rsp_t rsp_in,
  output logic room,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  rsp_t       buf_mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;
  logic       pop;

  assign room      = (count != 2'd2);
  assign rsp_valid = (count != 2'd0);
  assign rsp       = buf_mem[rd_ptr];
  assign pop       = rsp_valid && !rsp_stall;

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_mem[wr_ptr] <= rsp_in;
    end
  end

endmodule

@@ hdl/dependency_level_assigner_unit.sv @@
// channel  dir  handshake            payload
// req      in   req_valid/req_stall  req_t: req_type, dest_tensor, src_a, src_b, new_set
// rsp      out  rsp_valid/rsp_stall  rsp_t: level, level_count_minus_one
// a request issues only when the back part is not computing and the result buffer has room:
// issue reads the level tables, the next cycle computes the level and writes back; src_b
// of a multiply lands in the cycle after that and is forwarded to the following request
// with nothing queued a request passes issue, then compute, then the result buffer
// rst clears queues, valid bits and the running highest level; tables need no clear
// a stalled response backs up into the two-entry result buffer, then the request queue
// top level of the dependency level assigner; uses dla_pkg, dla_front, dla_back, dla_out
`include "dependency_level_assigner_unit_assert.svh"
module dependency_level_assigner_unit import dla_pkg::*; #(
  parameter int NUM_BUFFERS = NUM_BUFFERS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  logic  op_valid;
  logic  op_pop;
  op_t   op;
  logic  room;
  logic  push;
  rsp_t  rsp_int;
  stat_t stat;

  dla_front #(
    .NUM_BUFFERS(NUM_BUFFERS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .op_valid  (op_valid),
    .op_pop    (op_pop),
    .op        (op)
  );

  dla_back #(
    .NUM_BUFFERS(NUM_BUFFERS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (op_valid),
    .op       (op),
    .op_pop   (op_pop),
    .room     (room),
    .push     (push),
    .rsp      (rsp_int),
    .stat     (stat)
  );

  dla_out u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .rsp_in    (rsp_int),
    .room      (room),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  `DLA_ASSERT_NEXT(a_issue_then_push, stat.issue, stat.push, "issued request gave no result")
  `DLA_ASSERT_NOW(a_no_overlap, stat.push, !stat.issue, "issue overlapped the compute cycle")
  `DLA_ASSERT_NOW(a_issue_ok, stat.issue, op_valid && room, "issue without request or room")

endmodule

@@ sim/dla_level_checker.sv @@
// response checker for the dependency level assigner: watches both channels,
// predicts each response from its own copy of the buffer level tables and counts mismatches
// depends on dla_pkg only
module dla_level_checker import dla_pkg::*; #(
  parameter int NUM_BUFS = NUM_BUFFERS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_stall,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_stall,
  input  rsp_t rsp,
  output int   fails,
  output int   expected_left
);

  localparam int TOP_LEVEL = (1 << LEVEL_BITS) - 1;

  level_t writer_lvl [NUM_BUFS];
  bit     writer_seen [NUM_BUFS];
  level_t reader_lvl [NUM_BUFS];
  bit     reader_seen [NUM_BUFS];
  level_t peak;
  rsp_t   levels_due [$];
  int     bad = 0;

  function automatic void forget_history();
    for (int i = 0; i < NUM_BUFS; i++) begin
      writer_seen[i] = 1'b0;
      reader_seen[i] = 1'b0;
    end
    peak = '0;
  endfunction

  // the larger of bound and one past a recorded level, held at the top of the range
  function automatic int after_level(int bound, bit seen, level_t l);
    int next;
    if (!seen) return bound;
    next = (int'(l) >= TOP_LEVEL) ? TOP_LEVEL : int'(l) + 1;
    return (next > bound) ? next : bound;
  endfunction

  function automatic void note_read(idx_t idx, int lvl);
    if (int'(idx) >= NUM_BUFS) return;
    if (!reader_seen[idx] || int'(reader_lvl[idx]) < lvl) reader_lvl[idx] = level_t'(lvl);
    reader_seen[idx] = 1'b1;
  endfunction

  function automatic rsp_t assign_level(req_t r);
    int   lvl;
    rsp_t res;
    if (r.new_set) forget_history();
    lvl = 0;
    if (int'(r.src_a) < NUM_BUFS)
      lvl = after_level(lvl, writer_seen[r.src_a], writer_lvl[r.src_a]);
    if (r.req_type == OP_MUL && int'(r.src_b) < NUM_BUFS)
      lvl = after_level(lvl, writer_seen[r.src_b], writer_lvl[r.src_b]);
    if (int'(r.dest_tensor) < NUM_BUFS) begin
      lvl = after_level(lvl, reader_seen[r.dest_tensor], reader_lvl[r.dest_tensor]);
      if (!writer_seen[r.dest_tensor] || int'(writer_lvl[r.dest_tensor]) < lvl)
        writer_lvl[r.dest_tensor] = level_t'(lvl);
      writer_seen[r.dest_tensor] = 1'b1;
    end
    note_read(r.src_a, lvl);
    if (r.req_type == OP_MUL) note_read(r.src_b, lvl);
    if (lvl > int'(peak)) peak = level_t'(lvl);
    res.level = level_t'(lvl);
    res.level_count_minus_one = peak;
    return res;
  endfunction

  task automatic flag(string what, int want, int got);
    bad++;
    if (bad <= 10) $display("%0t: %s expected %0d got %0d", $time, what, want, got);
  endtask

  always @(posedge clk) begin : watch
    rsp_t want;
    if (rst) begin
      forget_history();
      levels_due.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (levels_due.size() == 0) begin
          bad++;
          if (bad <= 10)
            $display("%0t: response with no request waiting, level %0d count %0d",
                     $time, rsp.level, rsp.level_count_minus_one);
        end else begin
          want = levels_due.pop_front();
          if (rsp.level !== want.level) flag("level", int'(want.level), int'(rsp.level));
          if (rsp.level_count_minus_one !== want.level_count_minus_one)
            flag("level_count_minus_one", int'(want.level_count_minus_one),
                 int'(rsp.level_count_minus_one));
        end
      end
      if (req_valid && !req_stall) levels_due = {levels_due, assign_level(req)};
    end
    expected_left <= levels_due.size();
    fails <= bad;
  end

endmodule

@@ sim/dependency_level_assigner_unit_tb.sv @@
// testbench top for the dependency level assigner: drives directed, long-chain and random
// request streams with random idling on both sides and gives the verdict
// depends on dla_pkg, dependency_level_assigner_unit and dla_level_checker
module dependency_level_assigner_unit_tb;
  import dla_pkg::*;

  localparam int IDLE_LIMIT     = 2000;
  localparam int SQUEEZE_CYCLES = 300;
  localparam int CHAIN_LEN      = 300;
  localparam int RANDOM_BLOCKS  = 8;
  localparam int BLOCK_LEN      = 50;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;
  int   fails;
  int   expected_left;
  bit   squeeze;
  bit   calm;
  int   idle = 0;

  always #6 clk = ~clk;

  dependency_level_assigner_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  dla_level_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .req           (req),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .rsp           (rsp),
    .fails         (fails),
    .expected_left (expected_left)
  );

  function automatic req_t mk_op(logic kind, int d, int a, int b, bit fresh);
    req_t r;
    r.req_type    = kind;
    r.dest_tensor = idx_t'(d);
    r.src_a       = idx_t'(a);
    r.src_b       = idx_t'(b);
    r.new_set     = fresh;
    return r;
  endfunction

  // mostly a narrow window of buffers so that dependences pile up
  function automatic req_t next_op(int base);
    req_t r;
    r.req_type = $urandom_range(1) ? OP_MUL : OP_ADD;
    r.new_set  = ($urandom_range(99) < 3);
    if ($urandom_range(99) < 75) begin
      r.dest_tensor = idx_t'(base + $urandom_range(7));
      r.src_a       = idx_t'(base + $urandom_range(7));
      r.src_b       = idx_t'(base + $urandom_range(7));
    end else begin
      r.dest_tensor = idx_t'($urandom);
      r.src_a       = idx_t'($urandom);
      r.src_b       = idx_t'($urandom);
    end
    return r;
  endfunction

  function automatic int pick_gap(bit no_idle);
    int p;
    if (no_idle) return 0;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send(input req_t r);
    int gap;
    gap = pick_gap(calm);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  initial begin : stimulus
    int   base;
    req_t r;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    calm = 1'b0;
    squeeze = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send(mk_op(OP_ADD, 0, 0, 0, 0));
    send(mk_op(OP_ADD, 63, 63, 63, 0));
    send(mk_op(OP_MUL, 1, 0, 63, 0));
    send(mk_op(OP_ADD, 0, 5, 1, 0));
    send(mk_op(OP_MUL, 2, 1, 1, 0));
    send(mk_op(OP_ADD, 3, 3, 0, 0));
    send(mk_op(OP_MUL, 4, 4, 4, 0));
    send(mk_op(OP_ADD, 10, 20, 0, 0));
    send(mk_op(OP_ADD, 10, 21, 0, 0));
    send(mk_op(OP_ADD, 1, 1, 0, 1));
    send(mk_op(OP_MUL, 63, 0, 63, 1));
    send(mk_op(OP_MUL, 63, 63, 63, 1));
    send(mk_op(OP_ADD, 0, 0, 0, 0));
    send(mk_op(OP_MUL, 0, 63, 0, 0));

    // one long chain on a single buffer builds up deep levels
    base = $urandom_range(63);
    for (int n = 0; n < CHAIN_LEN; n++) begin
      r = next_op(base);
      r.dest_tensor = idx_t'(base);
      r.src_a = idx_t'(base);
      r.new_set = (n == 0);
      send(r);
    end

    // receiver holds off while requests keep coming
    calm = 1'b1;
    squeeze <= 1'b1;
    base = $urandom_range(63);
    for (int n = 0; n < 120; n++) send(next_op(base));
    squeeze <= 1'b0;

    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      calm = ($urandom_range(3) == 0);
      base = $urandom_range(63);
      for (int n = 0; n < BLOCK_LEN; n++) send(next_op(base));
    end

    req_valid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (fails == 0 && expected_left == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : receiver
    bit squeezed;
    int p;
    int n;
    rsp_stall = 1'b0;
    squeezed = 1'b0;
    forever begin
      p = $urandom_range(99);
      if (squeeze && !squeezed) begin
        squeezed = 1'b1;
        rsp_stall <= 1'b1;
        n = SQUEEZE_CYCLES;
      end else if (p < 20) begin
        rsp_stall <= 1'b0;
        n = $urandom_range(20, 60);
      end else if (p < 70) begin
        rsp_stall <= 1'b0;
        n = $urandom_range(1, 4);
      end else if (p < 95) begin
        rsp_stall <= 1'b1;
        n = $urandom_range(1, 3);
      end else begin
        rsp_stall <= 1'b1;
        n = $urandom_range(10, 40);
      end
      repeat (n) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle <= 0;
    end else if (idle >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle <= idle + 1;
    end
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/dla_pkg.sv
hdl/dla_front.sv
hdl/dla_back.sv
hdl/dla_out.sv
hdl/dependency_level_assigner_unit.sv
sim/dla_level_checker.sv
sim/dependency_level_assigner_unit_tb.sv
